FILE: src/assert_macros.svh
// Assertion macros shared by the extension hash classifier RTL.
// Depends on nothing; the SYNTH define selects empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FEHC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FEHC_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FEHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FEHC_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: src/fehc_pkg.sv
// Package for the file extension hash classifier: item types, queue types,
// video hash constants and the hash step functions. Depends on nothing.
package fehc_pkg;

  localparam int FEHC_QUEUE_DEPTH = 4;
  localparam int NUM_VIDEO = 7;

  localparam logic [7:0]  CHAR_DOT     = 8'h2E;
  localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
  localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0]  CASE_OFFSET  = 8'h20;
  localparam logic [63:0] ZERO_SUBST   = 64'h0000_0000_dead_beef;

  localparam logic [63:0] VIDEO_HASHES [NUM_VIDEO] = '{
    64'h007A_5309_81FE_BBAA,
    64'h007A_6D31_58CF_00AC,
    64'h007A_7023_76D8_30F6,
    64'hEC59_D091_62FE_6667,
    64'h007A_5306_53BC_5F32,
    64'h006D_0241_B8BE_6BDE,
    64'h0085_D1C9_16AE_EA68
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] ext_hash;
    logic        has_extension;
    logic        is_video;
  } out_item_t;

  typedef struct packed {
    logic [63:0] raw_hash;
    logic        dot_seen;
  } fehc_entry_t;

  typedef struct packed {
    logic        valid;
    fehc_entry_t entry;
  } fehc_push_t;

  typedef struct packed {
    logic        valid;
    fehc_entry_t entry;
  } fehc_head_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic [63:0] mix_byte(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] ha;
    logic [63:0] hb;
    ha = h + {56'd0, fold_case(b)};
    hb = ha + (ha << 10);
    return hb ^ (hb >> 6);
  endfunction

  function automatic logic [63:0] finish_hash(input logic [63:0] h);
    logic [63:0] h1;
    logic [63:0] h2;
    logic [63:0] h3;
    h1 = h + (h << 3);
    h2 = h1 ^ (h1 >> 11);
    h3 = h2 + (h2 << 15);
    if (h3 == 64'd0) begin
      h3 = ZERO_SUBST;
    end
    return h3;
  endfunction

  function automatic logic match_video(input logic [63:0] h);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_VIDEO; i++) begin
      if (h == VIDEO_HASHES[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

FILE: src/file_extension_hash_classifier.sv
// Top level of the file extension hash classifier.
// Instantiates fehc_front, fehc_queue and fehc_back; uses fehc_pkg.
//
// Usage: send a file name one byte per in_ item (in_item.ch), with
// in_item.last set on its final byte. Bytes after the most recent '.' are
// lowercased and folded into a 64-bit one-at-a-time hash; a dot restarts it.
// One out_ item per name carries the finalized hash (0 if the name had no
// dot), has_extension and is_video (match against seven video hashes).
// Throughput: one byte per cycle while in_stall is low, names back to back,
// no gap between names. The result of a name passes through the queue
// entry, the finalize stage and the compare/output reg.
// The front end stalls only when the QUEUE_DEPTH-entry result queue is full,
// which happens only while out_stall holds results back; a stalled result
// stays unchanged on out_item. Reset (rst_n low, synchronous) clears the
// running hash, the dot flag, the queue and all valid flags.
module file_extension_hash_classifier import fehc_pkg::*; #(
  parameter int QUEUE_DEPTH = FEHC_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  fehc_push_t push;
  fehc_head_t head;
  logic       q_full;
  logic       pop;

  fehc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push)
  );

  fehc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  fehc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: src/fehc_front.sv
// Front end: accepts name bytes, keeps the running extension hash and the
// dot flag, and pushes one entry per name into the queue. Uses fehc_pkg.
module fehc_front import fehc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  input  logic       q_full,
  output fehc_push_t push
);

  logic [63:0] hash_r;
  logic [63:0] hash_nxt;
  logic        dot_r;
  logic        dot_nxt;
  logic [63:0] step_hash;
  logic        step_dot;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    if (in_item.ch == CHAR_DOT) begin
      step_hash = 64'd0;
      step_dot  = 1'b1;
    end else begin
      step_hash = mix_byte(hash_r, in_item.ch);
      step_dot  = dot_r;
    end
  end

  always_comb begin
    hash_nxt = hash_r;
    dot_nxt  = dot_r;
    if (accept) begin
      if (in_item.last) begin
        hash_nxt = 64'd0;
        dot_nxt  = 1'b0;
      end else begin
        hash_nxt = step_hash;
        dot_nxt  = step_dot;
      end
    end
  end

  always_comb begin
    push.valid          = accept && in_item.last;
    push.entry.raw_hash = step_hash;
    push.entry.dot_seen = step_dot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= 64'd0;
      dot_r  <= 1'b0;
    end else begin
      hash_r <= hash_nxt;
      dot_r  <= dot_nxt;
    end
  end

endmodule

FILE: src/fehc_queue.sv
// Short queue between front and back ends, one entry per finished name.
// Uses fehc_pkg and assert_macros.svh. DEPTH must be a power of two.
`include "assert_macros.svh"
module fehc_queue import fehc_pkg::*; #(
  parameter int DEPTH = FEHC_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  fehc_push_t push,
  output logic       full,
  output fehc_head_t head,
  input  logic       pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fehc_entry_t   mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `FEHC_NEVER(a_no_push_full, clk, rst_n, push.valid && full, "push into full queue")
  `FEHC_NEVER(a_no_pop_empty, clk, rst_n, pop && !head.valid, "pop from empty queue")
  `FEHC_ASSERT(a_count_ptrs, clk, rst_n, (count_r != '0 && count_r != CW'(DEPTH)) |-> (wr_ptr_r != rd_ptr_r), "count and pointers disagree")

endmodule

FILE: src/fehc_back.sv
// Back end: finalizes the queued hash, then compares it with the video
// hashes into the output register. Uses fehc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fehc_back import fehc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fehc_head_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  logic        s1_valid_r;
  logic [63:0] s1_hash_r;
  logic        s1_dot_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        out_ld;
  logic        s1_ld;

  assign out_ld    = !out_valid_r || !out_stall;
  assign s1_ld     = !s1_valid_r || out_ld;
  assign pop       = head.valid && s1_ld;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_hash_r <= head.entry.dot_seen ? finish_hash(head.entry.raw_hash) : 64'd0;
      s1_dot_r  <= head.entry.dot_seen;
    end
    if (out_ld) begin
      out_item_r.ext_hash      <= s1_hash_r;
      out_item_r.has_extension <= s1_dot_r;
      out_item_r.is_video      <= s1_dot_r && match_video(s1_hash_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_valid_r <= head.valid;
      end
      if (out_ld) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  `FEHC_ASSERT(a_no_ext_zero, clk, rst_n, (out_valid_r && !out_item_r.has_extension) |-> (out_item_r.ext_hash == 64'd0), "no extension but nonzero hash")
  `FEHC_ASSERT(a_ext_nonzero, clk, rst_n, (out_valid_r && out_item_r.has_extension) |-> (out_item_r.ext_hash != 64'd0), "extension with zero hash")
  `FEHC_ASSERT(a_video_ext, clk, rst_n, (out_valid_r && out_item_r.is_video) |-> out_item_r.has_extension, "video match without extension")

endmodule
